// ----- rtl/core/pmd_pkg.sv -----
// ----------------------------------------------------------------------------
// pmd_pkg
// Shared widths, register indexes, reset values and bundle types for the
// passive-infrared motion detector.
// ----------------------------------------------------------------------------
package pmd_pkg;

   // Field widths
   localparam int SAMPLE_BITS    = 10;
   localparam int ENERGY_BITS    = 32;
   localparam int MAG_BITS       = 6;
   localparam int CFG_BITS       = 8;
   localparam int FILT_BITS      = 8;
   localparam int HIT_BITS       = 16;
   localparam int CSR_INDEX_BITS = 3;

   // Change size clamp
   localparam logic [MAG_BITS-1:0] MAG_MAX = 6'd63;

   // Filter adds a rounding term of 4 before the divide by four
   localparam int FILT_SUM_BITS = FILT_BITS + 2;
   localparam logic [FILT_SUM_BITS-1:0] FILT_ROUND = 10'd4;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SUSPECT_LEVEL   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SUSPECT_LIMIT   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RELEASE_TICKS   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DISARM_TICKS    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEVEL_THRESHOLD = 3'd4;

   // Register reset values
   localparam logic [CFG_BITS-1:0] RST_SUSPECT_LEVEL   = 8'd8;
   localparam logic [CFG_BITS-1:0] RST_SUSPECT_LIMIT   = 8'd4;
   localparam logic [CFG_BITS-1:0] RST_RELEASE_TICKS   = 8'd50;
   localparam logic [CFG_BITS-1:0] RST_DISARM_TICKS    = 8'd100;
   localparam logic [CFG_BITS-1:0] RST_LEVEL_THRESHOLD = 8'd40;

   typedef struct packed {
      logic [CFG_BITS-1:0] suspect_level;
      logic [CFG_BITS-1:0] suspect_limit;
      logic [CFG_BITS-1:0] release_ticks;
      logic [CFG_BITS-1:0] disarm_ticks;
      logic [CFG_BITS-1:0] level_threshold;
   } cfg_type;

   // Detection results for the request now being accepted
   typedef struct packed {
      logic                 motion;
      logic [FILT_BITS-1:0] filter_level;
      logic [HIT_BITS-1:0]  distant_count;
      logic [HIT_BITS-1:0]  close_count;
   } det_result_type;

endpackage

// ----- rtl/core/pir_motion_detector.sv -----
// ----------------------------------------------------------------------------
// pir_motion_detector
// Passive-infrared motion detector: change magnitude, energy total, IIR
// level filter, distant (suspicion) and close (threshold) detection.
// ----------------------------------------------------------------------------
//  channel   ports                        direction
//  request   req_valid/req_ready/req_*    in   one converter sample
//  response  rsp_valid/rsp_ready/rsp_*    out  one result per request
//  csr       csr_wen/csr_index/csr_wdata  in   register writes, no wait
//
// One request per cycle while the output register is empty or being
// drained in the same cycle; its result appears in the output register
// the cycle after acceptance, as all state updates at the accepting edge.
// Reset is synchronous and needs no clearing pass; configuration and
// detector state return to their defaults, but not the response payload.
// ----------------------------------------------------------------------------
module pir_motion_detector (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [pmd_pkg::SAMPLE_BITS-1:0]     req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_motion,
   output logic [pmd_pkg::MAG_BITS-1:0]        rsp_abs_change,
   output logic [pmd_pkg::FILT_BITS-1:0]       rsp_filter_level,
   output logic [pmd_pkg::ENERGY_BITS-1:0]     rsp_energy_total,
   output logic [pmd_pkg::HIT_BITS-1:0]        rsp_distant_count,
   output logic [pmd_pkg::HIT_BITS-1:0]        rsp_close_count,
   input  logic                                csr_wen,
   input  logic [pmd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [pmd_pkg::CFG_BITS-1:0]        csr_wdata
);
   import pmd_pkg::*;

   cfg_type              cfg_ff;
   logic                 accept;
   logic                 rsp_valid_ff;
   logic [MAG_BITS-1:0]  mag;
   logic [ENERGY_BITS-1:0] energy_next;
   det_result_type       det_result;

   logic                   motion_ff;
   logic [MAG_BITS-1:0]    abs_change_ff;
   logic [FILT_BITS-1:0]   filter_level_ff;
   logic [ENERGY_BITS-1:0] energy_total_ff;
   logic [HIT_BITS-1:0]    distant_count_ff;
   logic [HIT_BITS-1:0]    close_count_ff;

   // Configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.suspect_level   <= RST_SUSPECT_LEVEL;
         cfg_ff.suspect_limit   <= RST_SUSPECT_LIMIT;
         cfg_ff.release_ticks   <= RST_RELEASE_TICKS;
         cfg_ff.disarm_ticks    <= RST_DISARM_TICKS;
         cfg_ff.level_threshold <= RST_LEVEL_THRESHOLD;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_SUSPECT_LEVEL:   cfg_ff.suspect_level   <= csr_wdata;
            CSR_SUSPECT_LIMIT:   cfg_ff.suspect_limit   <= csr_wdata;
            CSR_RELEASE_TICKS:   cfg_ff.release_ticks   <= csr_wdata;
            CSR_DISARM_TICKS:    cfg_ff.disarm_ticks    <= csr_wdata;
            CSR_LEVEL_THRESHOLD: cfg_ff.level_threshold <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Handshake: output register frees up in the same cycle it drains
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   pmd_change u_change (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .sample      (req_sample),
      .mag         (mag),
      .energy_next (energy_next)
   );

   pmd_detect u_detect (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .cfg    (cfg_ff),
      .mag    (mag),
      .result (det_result)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         motion_ff        <= det_result.motion;
         abs_change_ff    <= mag;
         filter_level_ff  <= det_result.filter_level;
         energy_total_ff  <= energy_next;
         distant_count_ff <= det_result.distant_count;
         close_count_ff   <= det_result.close_count;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_motion        = motion_ff;
   assign rsp_abs_change    = abs_change_ff;
   assign rsp_filter_level  = filter_level_ff;
   assign rsp_energy_total  = energy_total_ff;
   assign rsp_distant_count = distant_count_ff;
   assign rsp_close_count   = close_count_ff;

   // An accepted request always shows up in the output register
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted request did not produce a response");

   // A detection disarms the detector, so two accepted requests in a row
   // never both pulse motion
   a_motion_pulse: assert property (@(posedge clock) disable iff (reset)
      (accept && det_result.motion) |=> !(accept && det_result.motion))
      else $error("motion pulsed on two consecutive requests");

   // Motion only appears together with a step of one hit counter
   a_motion_counts: assert property (@(posedge clock) disable iff (reset)
      (accept && det_result.motion) |->
         (det_result.distant_count != u_detect.distant_ff ||
          det_result.close_count   != u_detect.close_ff))
      else $error("motion without a hit count");

endmodule

// ----- rtl/core/pmd_change.sv -----
// ----------------------------------------------------------------------------
// pmd_change
// Sample-to-sample change magnitude (clamped) and the wrapping energy total.
// ----------------------------------------------------------------------------
module pmd_change (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [pmd_pkg::SAMPLE_BITS-1:0]  sample,
   output logic [pmd_pkg::MAG_BITS-1:0]     mag,
   output logic [pmd_pkg::ENERGY_BITS-1:0]  energy_next
);
   import pmd_pkg::*;

   logic [SAMPLE_BITS-1:0] prev_sample_ff;
   logic [ENERGY_BITS-1:0] energy_ff;
   logic signed [SAMPLE_BITS:0] diff;
   logic [SAMPLE_BITS:0] diff_abs;

   // Signed difference and its magnitude
   assign diff     = $signed({1'b0, sample}) - $signed({1'b0, prev_sample_ff});
   assign diff_abs = diff[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-diff) : diff;

   // Clamp to the largest change size
   assign mag = (diff_abs > (SAMPLE_BITS+1)'(MAG_MAX)) ? MAG_MAX : diff_abs[MAG_BITS-1:0];

   assign energy_next = energy_ff + ENERGY_BITS'(mag);

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_sample_ff <= '0;
         energy_ff      <= '0;
      end else if (accept) begin
         prev_sample_ff <= sample;
         energy_ff      <= energy_next;
      end
   end

endmodule

// ----- rtl/core/pmd_detect.sv -----
// ----------------------------------------------------------------------------
// pmd_detect
// Low-pass filter, suspicion counter with release timer, and the
// armed/disarmed detection control with its hit counters.
// ----------------------------------------------------------------------------
module pmd_detect (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  pmd_pkg::cfg_type              cfg,
   input  logic [pmd_pkg::MAG_BITS-1:0]  mag,
   output pmd_pkg::det_result_type       result
);
   import pmd_pkg::*;

   logic [FILT_BITS-1:0] filter_ff, filter_in;
   logic [CFG_BITS-1:0]  release_ff, release_in;
   logic [CFG_BITS-1:0]  suspicion_ff, suspicion_in;
   logic                 detected_ff, detected_in;
   logic [CFG_BITS-1:0]  disarm_ff, disarm_in;
   logic [HIT_BITS-1:0]  distant_ff, distant_in;
   logic [HIT_BITS-1:0]  close_ff, close_in;

   logic [FILT_SUM_BITS-1:0] filt_raw;
   logic [FILT_BITS-1:0]     filt_pre;
   logic                     raise;
   logic [CFG_BITS-1:0]      suspicion_mid;
   logic [CFG_BITS-1:0]      disarm_load;
   logic [CFG_BITS-1:0]      disarm_dec;
   logic                     rearm;

   // Filter: (3*f + 4*mag + 4) / 4
   assign filt_raw = {2'b00, filter_ff} + {1'b0, filter_ff, 1'b0}
                   + {2'b00, mag, 2'b00} + FILT_ROUND;
   assign filt_pre = filt_raw[FILT_SUM_BITS-1:2];

   assign raise = ({2'b00, mag} >= cfg.suspect_level) && (suspicion_ff < cfg.suspect_limit);

   // Suspicion counter and release timer
   always_comb begin
      release_in    = release_ff;
      suspicion_mid = suspicion_ff;
      if (raise) begin
         release_in    = cfg.release_ticks;
         suspicion_mid = suspicion_ff + 8'd1;
      end else if (release_ff != '0) begin
         release_in = release_ff - 8'd1;
      end else if (suspicion_ff != '0) begin
         suspicion_mid = suspicion_ff - 8'd1;
         release_in    = cfg.release_ticks;
      end
   end

   // Disarm timeout: an expired timer reloads before the decrement
   assign disarm_load = (disarm_ff == '0) ? cfg.disarm_ticks : disarm_ff;
   assign disarm_dec  = disarm_load - 8'd1;

   // Armed / disarmed control
   always_comb begin
      suspicion_in = suspicion_mid;
      filter_in    = filt_pre;
      disarm_in    = disarm_ff;
      detected_in  = detected_ff;
      distant_in   = distant_ff;
      close_in     = close_ff;
      rearm        = 1'b0;
      if (detected_ff) begin
         if (filt_pre < cfg.level_threshold) begin
            rearm = 1'b1;
         end else begin
            disarm_in = disarm_dec;
            rearm     = (disarm_dec == '0);
         end
         if (rearm) begin
            disarm_in    = '0;
            suspicion_in = '0;
            filter_in    = '0;
            detected_in  = 1'b0;
         end
      end else if (suspicion_mid >= cfg.suspect_limit) begin
         detected_in = 1'b1;
         distant_in  = distant_ff + 16'd1;
      end else if (filt_pre >= cfg.level_threshold) begin
         detected_in = 1'b1;
         close_in    = close_ff + 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_ff    <= '0;
         release_ff   <= '0;
         suspicion_ff <= '0;
         detected_ff  <= 1'b1;
         disarm_ff    <= 8'd1;
         distant_ff   <= '0;
         close_ff     <= '0;
      end else if (accept) begin
         filter_ff    <= filter_in;
         release_ff   <= release_in;
         suspicion_ff <= suspicion_in;
         detected_ff  <= detected_in;
         disarm_ff    <= disarm_in;
         distant_ff   <= distant_in;
         close_ff     <= close_in;
      end
   end

   // Motion pulses only on the step that makes a new detection
   assign result.motion        = detected_in && (disarm_in == '0);
   assign result.filter_level  = filter_in;
   assign result.distant_count = distant_in;
   assign result.close_count   = close_in;

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the passive-infrared motion detector. A directed
// request table, then shaped random sensor traces under several register
// settings. Every response is checked against a cycle-free predictor or
// a typed row's own values. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module tb;
   import pmd_pkg::*;

   // One response as seen on the rsp_ ports
   typedef struct packed {
      logic                   motion;
      logic [MAG_BITS-1:0]    abs_change;
      logic [FILT_BITS-1:0]   filter_level;
      logic [ENERGY_BITS-1:0] energy_total;
      logic [HIT_BITS-1:0]    distant_count;
      logic [HIT_BITS-1:0]    close_count;
   } pir_result_type;

   // Directed request: typed rows carry a hand-computed response
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic                   typed;
      pir_result_type         want;
   } directed_row_type;

   typedef enum {SEG_QUIET, SEG_SWING, SEG_DRIFT, SEG_JUMP, SEG_EXTREME} segment_kind_type;
   typedef enum {RX_OPEN, RX_SPARSE, RX_TOGGLE, RX_HEAVY} stall_style_type;

   localparam int SAMPLE_MAX     = 2**SAMPLE_BITS - 1;
   localparam int LONG_HOLD      = 300;
   localparam int SETTLE_CYCLES  = 2;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DENSE_ITEMS    = 60;

   localparam pir_result_type NO_RESULT = '0;

   // Reset start, full-scale swings, exact clamp edges, suspicion edge
   localparam directed_row_type DIRECTED [22] = '{
      '{10'd0,    1'b1, '{1'b0, 6'd0,  8'd0,   32'd0,   16'd0, 16'd0}},
      '{10'd1023, 1'b1, '{1'b1, 6'd63, 8'd64,  32'd63,  16'd0, 16'd1}},
      '{10'd0,    1'b1, '{1'b0, 6'd63, 8'd112, 32'd126, 16'd0, 16'd1}},
      '{10'd1023, 1'b0, NO_RESULT},
      '{10'd0,    1'b0, NO_RESULT},
      '{10'd1023, 1'b0, NO_RESULT},
      '{10'd512,  1'b0, NO_RESULT},
      '{10'd512,  1'b0, NO_RESULT},
      '{10'd512,  1'b0, NO_RESULT},
      '{10'd512,  1'b0, NO_RESULT},
      '{10'd512,  1'b0, NO_RESULT},
      '{10'd512,  1'b0, NO_RESULT},
      '{10'd512,  1'b0, NO_RESULT},
      '{10'd512,  1'b0, NO_RESULT},
      '{10'd575,  1'b0, NO_RESULT},
      '{10'd512,  1'b0, NO_RESULT},
      '{10'd576,  1'b0, NO_RESULT},
      '{10'd511,  1'b0, NO_RESULT},
      '{10'd519,  1'b0, NO_RESULT},
      '{10'd512,  1'b0, NO_RESULT},
      '{10'd1,    1'b0, NO_RESULT},
      '{10'd0,    1'b0, NO_RESULT}
   };

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_ready;
   logic [SAMPLE_BITS-1:0]    req_sample  = '0;
   logic                      rsp_valid;
   logic                      rsp_ready   = 1'b0;
   logic                      rsp_motion;
   logic [MAG_BITS-1:0]       rsp_abs_change;
   logic [FILT_BITS-1:0]      rsp_filter_level;
   logic [ENERGY_BITS-1:0]    rsp_energy_total;
   logic [HIT_BITS-1:0]       rsp_distant_count;
   logic [HIT_BITS-1:0]       rsp_close_count;
   logic                      csr_wen     = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index   = '0;
   logic [CFG_BITS-1:0]       csr_wdata   = '0;

   // Sideband held with the request payload
   logic                      typed_row    = 1'b0;
   pir_result_type            typed_result = '0;

   // Detector model state
   cfg_type                   cfg_now;
   logic [SAMPLE_BITS-1:0]    last_sample;
   logic [FILT_BITS-1:0]      level_sum;
   logic [CFG_BITS-1:0]       decay_timer;
   logic [CFG_BITS-1:0]       suspect_cnt;
   logic                      disarmed;
   logic [CFG_BITS-1:0]       hold_timer;
   logic [ENERGY_BITS-1:0]    energy_sum;
   logic [HIT_BITS-1:0]       distant_hits;
   logic [HIT_BITS-1:0]       close_hits;

   pir_result_type            pending_results [$];
   int                        failures       = 0;
   int                        stalled_cycles = 0;
   int                        burst_left     = 0;
   int                        sensor_base    = 512;
   bit                        hold_request   = 1'b0;

   pir_motion_detector DUT (
      .clock, .reset,
      .req_valid, .req_ready, .req_sample,
      .rsp_valid, .rsp_ready, .rsp_motion, .rsp_abs_change, .rsp_filter_level,
      .rsp_energy_total, .rsp_distant_count, .rsp_close_count,
      .csr_wen, .csr_index, .csr_wdata
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Advance the detector model by one sample and return its response
   function automatic pir_result_type predict_motion(logic [SAMPLE_BITS-1:0] s);
      pir_result_type      r;
      int                  step;
      int                  mixed;
      logic [MAG_BITS-1:0] mag;
      bit                  rearm;
      step = int'(s) - int'(last_sample);
      if (step > int'(MAG_MAX) || step < -int'(MAG_MAX)) begin
         mag = MAG_MAX;
      end else if (step < 0) begin
         mag = MAG_BITS'(-step);
      end else begin
         mag = MAG_BITS'(step);
      end

      energy_sum  = energy_sum + ENERGY_BITS'(mag);
      // three-quarter low-pass, rounded, two fraction bits
      mixed       = (int'(level_sum) * 3 + (int'(mag) << 2) + int'(FILT_ROUND)) >> 2;
      level_sum   = FILT_BITS'(mixed);
      last_sample = s;

      // suspicion rises on big changes, decays after the release time
      if ({2'b00, mag} >= cfg_now.suspect_level && suspect_cnt < cfg_now.suspect_limit) begin
         decay_timer = cfg_now.release_ticks;
         suspect_cnt = suspect_cnt + 8'd1;
      end else if (decay_timer != 0) begin
         decay_timer = decay_timer - 8'd1;
      end else if (suspect_cnt != 0) begin
         suspect_cnt = suspect_cnt - 8'd1;
         decay_timer = cfg_now.release_ticks;
      end

      if (disarmed) begin
         if (hold_timer == 0) hold_timer = cfg_now.disarm_ticks;
         if (level_sum < cfg_now.level_threshold) begin
            rearm = 1'b1;
         end else begin
            hold_timer = hold_timer - 8'd1;
            rearm      = (hold_timer == 0);
         end
         if (rearm) begin
            hold_timer  = '0;
            suspect_cnt = '0;
            level_sum   = '0;
            disarmed    = 1'b0;
         end
      end else if (suspect_cnt >= cfg_now.suspect_limit) begin
         disarmed     = 1'b1;
         distant_hits = distant_hits + 16'd1;
      end else if (level_sum >= cfg_now.level_threshold) begin
         disarmed   = 1'b1;
         close_hits = close_hits + 16'd1;
      end

      r.motion        = disarmed && (hold_timer == 0);
      r.abs_change    = mag;
      r.filter_level  = level_sum;
      r.energy_total  = energy_sum;
      r.distant_count = distant_hits;
      r.close_count   = close_hits;
      return r;
   endfunction

   function automatic void check_field(string name, logic [ENERGY_BITS-1:0] want,
                                       logic [ENERGY_BITS-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] clamp_sample(int v);
      if (v < 0) return '0;
      if (v > SAMPLE_MAX) return SAMPLE_BITS'(SAMPLE_MAX);
      return SAMPLE_BITS'(v);
   endfunction

   // Model update, prediction and response check
   always @(posedge clock) begin
      pir_result_type want;
      pir_result_type guess;
      if (reset) begin
         cfg_now      = '{RST_SUSPECT_LEVEL, RST_SUSPECT_LIMIT, RST_RELEASE_TICKS,
                          RST_DISARM_TICKS, RST_LEVEL_THRESHOLD};
         last_sample  = '0;
         level_sum    = '0;
         decay_timer  = '0;
         suspect_cnt  = '0;
         disarmed     = 1'b1;
         hold_timer   = 8'd1;
         energy_sum   = '0;
         distant_hits = '0;
         close_hits   = '0;
         pending_results.delete();
      end else begin
         if (csr_wen) begin
            case (csr_index)
               CSR_SUSPECT_LEVEL:   cfg_now.suspect_level   = csr_wdata;
               CSR_SUSPECT_LIMIT:   cfg_now.suspect_limit   = csr_wdata;
               CSR_RELEASE_TICKS:   cfg_now.release_ticks   = csr_wdata;
               CSR_DISARM_TICKS:    cfg_now.disarm_ticks    = csr_wdata;
               CSR_LEVEL_THRESHOLD: cfg_now.level_threshold = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("response with no request outstanding");
               failures++;
            end else begin
               want = pending_results.pop_front();
               check_field("motion", ENERGY_BITS'(want.motion), ENERGY_BITS'(rsp_motion));
               check_field("abs_change", ENERGY_BITS'(want.abs_change),
                           ENERGY_BITS'(rsp_abs_change));
               check_field("filter_level", ENERGY_BITS'(want.filter_level),
                           ENERGY_BITS'(rsp_filter_level));
               check_field("energy_total", want.energy_total, rsp_energy_total);
               check_field("distant_count", ENERGY_BITS'(want.distant_count),
                           ENERGY_BITS'(rsp_distant_count));
               check_field("close_count", ENERGY_BITS'(want.close_count),
                           ENERGY_BITS'(rsp_close_count));
            end
         end
         if (req_valid && req_ready) begin
            guess = predict_motion(req_sample);
            pending_results.push_back(typed_row ? typed_result : guess);
         end
      end
   end

   // Watchdog: too long without any transfer ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wen) begin
         stalled_cycles <= 0;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
      if (stalled_cycles == WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Receiver: stall styles in random spans, plus one long hold on request
   initial begin : receiver
      stall_style_type style;
      int              span;
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 1'b0;
         end
         style = stall_style_type'($urandom_range(0, 3));
         span  = $urandom_range(8, 60);
         repeat (span) begin
            case (style)
               RX_OPEN:   rsp_ready <= 1'b1;
               RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) != 0);
               RX_TOGGLE: rsp_ready <= ~rsp_ready;
               default:   rsp_ready <= ($urandom_range(0, 4) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   // Offer one request in burst/gap fashion; returns at the accepting edge
   task automatic offer_sample(logic [SAMPLE_BITS-1:0] s, logic typed,
                               pir_result_type want);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid    <= 1'b1;
      req_sample   <= s;
      typed_row    <= typed;
      typed_result <= want;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop sending and wait for every outstanding response
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all five registers, then junk into the unused indexes
   task automatic program_config(cfg_type c);
      logic [CFG_BITS-1:0] value;
      int                  i;
      for (i = 0; i < 2**CSR_INDEX_BITS; i++) begin
         case (CSR_INDEX_BITS'(i))
            CSR_SUSPECT_LEVEL:   value = c.suspect_level;
            CSR_SUSPECT_LIMIT:   value = c.suspect_limit;
            CSR_RELEASE_TICKS:   value = c.release_ticks;
            CSR_DISARM_TICKS:    value = c.disarm_ticks;
            CSR_LEVEL_THRESHOLD: value = c.level_threshold;
            default:             value = CFG_BITS'($urandom());
         endcase
         csr_wen   <= 1'b1;
         csr_index <= CSR_INDEX_BITS'(i);
         csr_wdata <= value;
         @(posedge clock);
      end
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   // Sensor-like traces: mostly quiet stretches, swings and drifts,
   // with some raw noise and full-scale hits
   task automatic run_random(int count);
      segment_kind_type       kind;
      logic [SAMPLE_BITS-1:0] s;
      int                     seg_left;
      int                     amp;
      int                     pick;
      int                     i;
      bit                     swing_up;
      seg_left = 0;
      swing_up = 1'b0;
      kind     = SEG_QUIET;
      amp      = 0;
      for (i = 0; i < count; i++) begin
         if (seg_left == 0) begin
            pick = $urandom_range(0, 9);
            if (pick < 3) kind = SEG_QUIET;
            else if (pick < 6) kind = SEG_SWING;
            else if (pick < 8) kind = SEG_DRIFT;
            else if (pick < 9) kind = SEG_JUMP;
            else kind = SEG_EXTREME;
            seg_left = (kind == SEG_QUIET) ? $urandom_range(10, 80) : $urandom_range(1, 30);
            amp      = $urandom_range(4, 120);
            if ($urandom_range(0, 3) == 0) sensor_base = $urandom_range(0, SAMPLE_MAX);
         end
         seg_left--;
         case (kind)
            SEG_QUIET: s = clamp_sample(sensor_base + int'($urandom_range(0, 6)) - 3);
            SEG_SWING: begin
               swing_up = !swing_up;
               s = clamp_sample(swing_up ? sensor_base + amp : sensor_base - amp);
            end
            SEG_DRIFT: begin
               sensor_base = int'(clamp_sample(sensor_base + int'($urandom_range(0, 140)) - 70));
               s = SAMPLE_BITS'(sensor_base);
            end
            SEG_JUMP:  s = SAMPLE_BITS'($urandom());
            default:   s = $urandom_range(0, 1) ? SAMPLE_BITS'(SAMPLE_MAX) : '0;
         endcase
         offer_sample(s, 1'b0, NO_RESULT);
      end
   endtask

   initial begin
      cfg_type cfg;
      int      i;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed table under reset settings
      for (i = 0; i < $size(DIRECTED); i++) begin
         offer_sample(DIRECTED[i].sample, DIRECTED[i].typed, DIRECTED[i].want);
      end
      run_random(150);
      // long receiver hold while requests keep coming
      hold_request = 1'b1;
      run_random(150);
      drain_results();

      // Extremes: every sample suspicious, instant disarm wrap, no close
      cfg = '{8'd0, 8'd255, 8'd0, 8'd0, 8'd255};
      program_config(cfg);
      run_random(250);
      drain_results();

      // Extremes: never suspicious, zero limit, longest timers
      cfg = '{8'd255, 8'd0, 8'd255, 8'd255, 8'd0};
      program_config(cfg);
      run_random(250);
      drain_results();

      // Zero disarm timeout: filter held high for more than 256 samples
      cfg = '{8'd255, 8'd255, 8'd10, 8'd0, 8'd20};
      program_config(cfg);
      for (i = 0; i < 300; i++) offer_sample(SAMPLE_BITS'((i % 2) * SAMPLE_MAX), 1'b0, NO_RESULT);
      for (i = 0; i < 30; i++) offer_sample(10'd512, 1'b0, NO_RESULT);
      drain_results();

      // Random settings, mostly in the sensitive range
      repeat (4) begin
         cfg.suspect_level   = CFG_BITS'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                                     : $urandom_range(0, 40));
         cfg.suspect_limit   = CFG_BITS'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                                     : $urandom_range(0, 8));
         cfg.release_ticks   = CFG_BITS'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                                     : $urandom_range(0, 30));
         cfg.disarm_ticks    = CFG_BITS'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                                     : $urandom_range(0, 20));
         cfg.level_threshold = CFG_BITS'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                                     : $urandom_range(0, 100));
         program_config(cfg);
         run_random(80);
         drain_results();
      end

      // Close detection every other sample
      cfg = '{8'd255, 8'd255, 8'd0, 8'd1, 8'd0};
      program_config(cfg);
      run_random(DENSE_ITEMS);
      drain_results();

      // Distant detection every other sample
      cfg = '{8'd255, 8'd0, 8'd0, 8'd1, 8'd255};
      program_config(cfg);
      run_random(DENSE_ITEMS);
      drain_results();

      if (failures == 0 && pending_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
